// ===== hdl/hook_pc_redirect_table_top_defines.svh =====
// ----------------------------------------------------------------------------
// hook_pc_redirect_table_top_defines.svh
// Assertion macros used by the redirect table top RTL.
// ----------------------------------------------------------------------------
`ifndef HOOK_PC_REDIRECT_TABLE_TOP_DEFINES_SVH
`define HOOK_PC_REDIRECT_TABLE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define HPRT_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define HPRT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define HPRT_ASSERT_IMPL(name, ante, cons, msg)
`define HPRT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ===== hdl/hprt_pkg.sv =====
// ----------------------------------------------------------------------------
// hprt_pkg
// Types and constants of the hook PC redirect table.
// ----------------------------------------------------------------------------
`default_nettype none

package hprt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      OUT_UNCHANGED  = 2'd0,
      OUT_WRAPPER    = 2'd1,
      OUT_NO_WRAPPER = 2'd2,
      OUT_COPY_MAP   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef enum logic {
      MODE_ORIG,
      MODE_COPY
   } mode_type;

   typedef struct packed {
      logic        action;
      logic [63:0] orig_addr;
      logic [63:0] copy_addr;
      logic [31:0] copy_len;
      logic [63:0] wrapper_addr;
      logic [63:0] pc_in;
   } req_word_type;

   typedef struct packed {
      logic [63:0] adjusted_pc;
      logic [1:0]  outcome;
      logic        insert_dropped;
   } rsp_word_type;

   // One stored hook record. delta is orig - copy, kept so that mapping a
   // copy address back to the original takes a single add.
   typedef struct packed {
      logic [63:0] orig;
      logic [63:0] delta;
      logic [63:0] copy;
      logic [63:0] copy_end;
      logic [63:0] wrapper;
   } record_type;

   typedef struct packed {
      logic in_orig;
      logic in_copy;
   } range_hit_type;

endpackage

`default_nettype wire

// ===== hdl/hprt_ram.sv =====
// ----------------------------------------------------------------------------
// hprt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hprt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/hprt_bounds.sv =====
// ----------------------------------------------------------------------------
// hprt_bounds
// Lowest and highest original addresses, lowest copy address and highest copy end, with the range tests.
// ----------------------------------------------------------------------------
`default_nettype none

module hprt_bounds
   import hprt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          upd_en,
   input  wire logic [63:0]   orig,
   input  wire logic [63:0]   copy,
   input  wire logic [63:0]   copy_end,
   input  wire logic [63:0]   pc,
   output      range_hit_type hit
);

   logic [63:0] lo_orig_ff, lo_orig_in;
   logic [63:0] hi_orig_ff, hi_orig_in;
   logic [63:0] lo_copy_ff, lo_copy_in;
   logic [63:0] hi_copy_ff, hi_copy_in;

   // A bound that holds zero is treated as never set.
   always_comb begin
      lo_orig_in = lo_orig_ff;
      hi_orig_in = hi_orig_ff;
      lo_copy_in = lo_copy_ff;
      hi_copy_in = hi_copy_ff;
      if (upd_en) begin
         if (lo_orig_ff == 64'd0 || lo_orig_ff > orig) lo_orig_in = orig;
         if (hi_orig_ff == 64'd0 || hi_orig_ff < orig) hi_orig_in = orig;
         if (lo_copy_ff == 64'd0 || lo_copy_ff > copy) lo_copy_in = copy;
         if (hi_copy_ff == 64'd0 || hi_copy_ff < copy_end) hi_copy_in = copy_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_orig_ff <= '0;
         hi_orig_ff <= '0;
         lo_copy_ff <= '0;
         hi_copy_ff <= '0;
      end else begin
         lo_orig_ff <= lo_orig_in;
         hi_orig_ff <= hi_orig_in;
         lo_copy_ff <= lo_copy_in;
         hi_copy_ff <= hi_copy_in;
      end
   end

   assign hit.in_orig = (pc >= lo_orig_ff) && (pc <= hi_orig_ff);
   assign hit.in_copy = (pc >= lo_copy_ff) && (pc <= hi_copy_ff);

endmodule

`default_nettype wire

// ===== hdl/hook_pc_redirect_table_top.sv =====
// ----------------------------------------------------------------------------
// hook_pc_redirect_table_top
// Hook record table that redirects or maps back program counters.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake              Word
//   req_      in          req_valid / req_stall  req_word_type
//   rsp_      out         rsp_valid / rsp_stall  rsp_word_type
//
// An insert is accepted, then handed off to the output register.
// A lookup that falls outside both ranges goes the same way; one that scans
// reads the records through the single read port of the record RAM, which
// delivers one record a cycle from a registered read.
// Reset clears the record count and the bounds; records need no clearing.
// The output register takes a new word only once the last result is no longer stalled.
`default_nettype none

`include "hook_pc_redirect_table_top_defines.svh"

module hook_pc_redirect_table_top
   import hprt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire req_word_type req_word,
   output      logic         rsp_valid,
   input  wire logic         rsp_stall,
   output      rsp_word_type rsp_word
);

   state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic         rd_valid_ff, rd_valid_in;
   mode_type     mode_ff, mode_in;
   logic [63:0]  pc_ff, pc_in;
   rsp_word_type res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic          accept;
   logic          full;
   logic          ins_en;
   logic          rd_en;
   logic          out_free;
   record_type    wr_rec;
   record_type    rd_rec;
   logic [$bits(record_type)-1:0] rd_bits;
   range_hit_type hit;
   logic          rec_hit;

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign ins_en = accept && (req_word.action == ACT_INSERT) && !full;
   assign rd_en  = (state_ff == ST_SCAN) && (issue_ff < count_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign wr_rec.orig     = req_word.orig_addr;
   assign wr_rec.delta    = req_word.orig_addr - req_word.copy_addr;
   assign wr_rec.copy     = req_word.copy_addr;
   assign wr_rec.copy_end = req_word.copy_addr + {32'd0, req_word.copy_len};
   assign wr_rec.wrapper  = req_word.wrapper_addr;

   hprt_ram #(
      .WIDTH ($bits(record_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ins_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_rec),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_bits)
   );

   assign rd_rec = record_type'(rd_bits);

   hprt_bounds u_bounds (
      .clock    (clock),
      .reset    (reset),
      .upd_en   (ins_en),
      .orig     (wr_rec.orig),
      .copy     (wr_rec.copy),
      .copy_end (wr_rec.copy_end),
      .pc       (req_word.pc_in),
      .hit      (hit)
   );

   always_comb begin
      if (mode_ff == MODE_ORIG) begin
         rec_hit = (rd_rec.orig == pc_ff);
      end else begin
         rec_hit = (pc_ff >= rd_rec.copy) && (pc_ff < rd_rec.copy_end);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      mode_in      = mode_ff;
      pc_in        = pc_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            pc_in    = req_word.pc_in;
            if (accept) begin
               if (req_word.action == ACT_INSERT) begin
                  if (!full) count_in = count_ff + 1'b1;
                  res_in.adjusted_pc    = '0;
                  res_in.outcome        = OUT_UNCHANGED;
                  res_in.insert_dropped = full;
                  state_in              = ST_EMIT;
               end else begin
                  res_in.adjusted_pc    = req_word.pc_in;
                  res_in.outcome        = OUT_UNCHANGED;
                  res_in.insert_dropped = 1'b0;
                  // The original range wins; the copy range is only tried
                  // when the PC lies outside it.
                  if (hit.in_orig) begin
                     mode_in  = MODE_ORIG;
                     state_in = ST_SCAN;
                  end else if (hit.in_copy) begin
                     mode_in  = MODE_COPY;
                     state_in = ST_SCAN;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (rd_valid_ff && rec_hit) begin
               if (mode_ff == MODE_ORIG) begin
                  if (rd_rec.wrapper != 64'd0) begin
                     res_in.adjusted_pc = rd_rec.wrapper;
                     res_in.outcome     = OUT_WRAPPER;
                  end else begin
                     res_in.outcome     = OUT_NO_WRAPPER;
                  end
               end else begin
                  res_in.adjusted_pc = pc_ff + rd_rec.delta;
                  res_in.outcome     = OUT_COPY_MAP;
               end
               state_in = ST_EMIT;
            end else if (!rd_en && !rd_valid_ff) begin
               // Every written record has been checked without a match.
               state_in = ST_EMIT;
            end else begin
               rd_valid_in = rd_en;
               if (rd_en) issue_in = issue_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      pc_ff       <= pc_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `HPRT_ASSERT_IMPL(a_count_max, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH), "record count overflow")
   `HPRT_ASSERT_IMPL(a_read_in_scan, rd_valid_ff, state_ff == ST_SCAN, "read data outside scan")
   `HPRT_ASSERT_NEXT(a_insert_count, ins_en, count_ff == $past(count_ff) + 1'b1, "insert lost")
   `HPRT_ASSERT_NEXT(a_emit_waits, (state_ff == ST_EMIT) && rsp_valid_ff && rsp_stall, state_ff == ST_EMIT, "result overwrote a stalled word")

endmodule

`default_nettype wire
